### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset
`define YPD_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define YPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define YPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ypd_pkg.sv
package ypd_pkg;

    localparam int unsigned WIN_LEN   = 7;
    localparam int unsigned HDR_LEN   = 4;
    localparam int unsigned SUM_LEN   = 6;
    localparam int unsigned CELL_CNT  = WIN_LEN - 1;
    localparam logic [31:0] HDR_RESET = 32'hA403_1802;

    typedef logic [7:0] t_byte;
    typedef logic [WIN_LEN-1:0][7:0] t_win;

    typedef struct packed {
        logic               frame_ok;
        logic signed [15:0] yaw_centidegrees;
        logic [31:0]        good_packets;
        logic [31:0]        bad_packets;
    } t_result;

    typedef struct packed {
        logic fire;
        logic clear;
    } t_chk_ctl;

endpackage

### rtl/ypd_ifs.sv
interface ypd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ypd_result_if;
    logic               valid;
    logic               ready;
    logic               frame_ok;
    logic signed [15:0] yaw_centidegrees;
    logic [31:0]        good_packets;
    logic [31:0]        bad_packets;

    modport source (output valid, output frame_ok, output yaw_centidegrees,
                    output good_packets, output bad_packets, input ready);
    modport sink   (input valid, input frame_ok, input yaw_centidegrees,
                    input good_packets, input bad_packets, output ready);
endinterface

interface ypd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_pattern;

    modport source (output valid, output header_pattern, input ready);
    modport sink   (input valid, input header_pattern, output ready);
endinterface

### rtl/ypd_cell.sv
module ypd_cell
    import ypd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_byte i_byte,
    input  logic  i_vld,
    output t_byte o_byte,
    output logic  o_vld
);

    t_byte r_byte;
    logic  r_vld;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // clear wins over shift: a good packet empties the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_clear) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    assign o_byte = r_byte;
    assign o_vld  = r_vld;

endmodule

### rtl/ypd_check.sv
`include "assert_macros.svh"

module ypd_check
    import ypd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_full,
    input  t_win        i_win,
    input  logic [31:0] i_header,
    output t_chk_ctl    o_ctl,
    output t_result     o_result
);

    logic [31:0] r_good;
    logic [31:0] r_bad;
    logic        hdr_hit;
    logic        hit;
    logic        ok;
    t_byte       sum;

    always_comb begin
        hdr_hit = 1'b1;
        for (int k = 0; k < HDR_LEN; k++) begin
            if (i_win[k] != i_header[31 - 8*k -: 8]) begin
                hdr_hit = 1'b0;
            end
        end
    end

    // 8-bit sum wraps naturally
    always_comb begin
        sum = '0;
        for (int k = 0; k < SUM_LEN; k++) begin
            sum = sum + i_win[k];
        end
    end

    assign hit = i_full && hdr_hit;
    assign ok  = (sum == i_win[WIN_LEN-1]);

    assign o_ctl.fire  = i_accept && hit;
    assign o_ctl.clear = i_accept && hit && ok;

    always_comb begin
        o_result.frame_ok         = ok;
        o_result.yaw_centidegrees = ok ? {i_win[4], i_win[5]} : 16'sd0;
        o_result.good_packets     = ok ? r_good + 32'd1 : r_good;
        o_result.bad_packets      = ok ? r_bad : r_bad + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good <= '0;
            r_bad  <= '0;
        end else if (o_ctl.fire) begin
            r_good <= o_result.good_packets;
            r_bad  <= o_result.bad_packets;
        end
    end

    `YPD_ASSERT_IMP(a_clear_fires, i_clk, i_rst_n, o_ctl.clear, o_ctl.fire)
    `YPD_ASSERT_NXT(a_good_step, i_clk, i_rst_n, o_ctl.clear,
        r_good == $past(r_good) + 32'd1 && r_bad == $past(r_bad))
    `YPD_ASSERT_NXT(a_idle_hold, i_clk, i_rst_n, !o_ctl.fire,
        r_good == $past(r_good) && r_bad == $past(r_bad))

endmodule

### rtl/ypd_obuf.sv
`include "assert_macros.svh"

module ypd_obuf
    import ypd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_vld;
    logic    r_skid_vld;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_vld && i_ready;
    assign o_space = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_main_vld <= i_push;
            end
        end else if (i_push) begin
            if (r_main_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_main_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_vld ? r_skid : i_result;
        end else if (i_push) begin
            if (r_main_vld) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

    `YPD_ASSERT(a_skid_needs_main, i_clk, i_rst_n, !r_skid_vld || r_main_vld)
    `YPD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, r_skid_vld, !i_push)
    `YPD_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, pop && r_skid_vld,
        r_main_vld && !r_skid_vld)

endmodule

### rtl/yaw_packet_deframer.sv
// A result item is registered into the output buffer from the byte that completes it.
// Throughput: one byte per cycle while ready; the six-cell window shifts on every accepted byte.
// A two-entry output buffer keeps input flowing while one result waits; ready drops on two.
// Reset (synchronous, active low): window empty, counters zero, header 0xA4031802,
// output buffer empty.
module yaw_packet_deframer
    import ypd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ypd_byte_if.sink     i_rx,
    ypd_cfg_if.sink      i_cfg,
    ypd_result_if.source o_res
);

    logic [31:0] r_header;
    t_byte       cell_byte [CELL_CNT];
    logic        cell_vld  [CELL_CNT];
    t_win        win;
    logic        accept;
    logic        space;
    t_chk_ctl    ctl;
    t_result     chk_result;
    t_result     out_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HDR_RESET;
        end else if (i_cfg.valid) begin
            r_header <= i_cfg.header_pattern;
        end
    end

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    // cell 0 holds the oldest byte; the newest enters at the top cell
    for (genvar k = 0; k < CELL_CNT; k++) begin : g_cell
        if (k == CELL_CNT - 1) begin : g_top
            ypd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_clear (ctl.clear),
                .i_byte  (i_rx.rx_byte),
                .i_vld   (1'b1),
                .o_byte  (cell_byte[k]),
                .o_vld   (cell_vld[k])
            );
        end else begin : g_mid
            ypd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_clear (ctl.clear),
                .i_byte  (cell_byte[k+1]),
                .i_vld   (cell_vld[k+1]),
                .o_byte  (cell_byte[k]),
                .o_vld   (cell_vld[k])
            );
        end
    end

    // window as it stands after this byte is pushed
    always_comb begin
        for (int k = 0; k < CELL_CNT; k++) begin
            win[k] = cell_byte[k];
        end
        win[WIN_LEN-1] = i_rx.rx_byte;
    end

    ypd_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_full   (cell_vld[0]),
        .i_win    (win),
        .i_header (r_header),
        .o_ctl    (ctl),
        .o_result (chk_result)
    );

    ypd_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (ctl.fire),
        .i_result (chk_result),
        .o_space  (space),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (out_result)
    );

    assign o_res.frame_ok         = out_result.frame_ok;
    assign o_res.yaw_centidegrees = out_result.yaw_centidegrees;
    assign o_res.good_packets     = out_result.good_packets;
    assign o_res.bad_packets      = out_result.bad_packets;

endmodule
